>>> hdl/sstm_pkg.sv
package sstm_pkg;

    localparam logic [15:0] SUB_US_MAX = 16'd999;
    localparam logic [31:0] CNT_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_CONNECT = 2'd0,
        FUNC_BATCH   = 2'd1,
        FUNC_SAMPLE  = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction

    // wrap-safe elapsed time, 0 unless strictly forward
    function automatic logic [30:0] fwd_elapsed(input logic [31:0] from_ms,
                                                input logic [31:0] to_ms);
        logic [31:0] d;
        d = to_ms - from_ms;
        return d[31] ? 31'd0 : d[30:0];
    endfunction

endpackage

>>> hdl/sensor_stream_timing_monitor_core.sv
// A request accepted into the input register passes on to the result register, which
// raises out_valid with its result. Throughput: one request per cycle while out_stall
// holds no result; the input register and the result register each hold one request,
// so a new request is taken while a result waits. Reset (rst_n, asynchronous, active
// low) clears all statistics and empties both registers.
module sensor_stream_timing_monitor_core
    import sstm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [31:0] uptime_ms,
    input  logic [15:0] field_count,
    input  logic [31:0] stamp_ms,
    input  logic [15:0] stamp_sub_us,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] total_samples,
    output logic [31:0] total_batches,
    output logic [30:0] longest_gap_ms,
    output logic [31:0] backward_count,
    output logic [31:0] bad_sub_count,
    output logic [15:0] first_fields,
    output logic [15:0] other_fields,
    output logic        fields_changed,
    output logic [30:0] first_sample_latency_ms,
    output logic signed [31:0] offset_drift_ms,
    output logic [30:0] skew_span_ms,
    output logic [30:0] stamp_span_ms
);

    // input register
    logic        in_valid_reg;
    func_t       func_reg;
    logic [31:0] uptime_reg;
    logic [15:0] fc_reg;
    logic [31:0] stamp_reg;
    logic [15:0] sub_reg;

    // result register
    logic        out_valid_reg;

    // statistics
    logic [31:0] sample_total_reg,   sample_total_next;
    logic [31:0] batch_total_reg,    batch_total_next;
    logic [31:0] connect_time_reg,   connect_time_next;
    logic        connected_seen_reg, connected_seen_next;
    logic [30:0] first_latency_reg,  first_latency_next;
    logic        first_done_reg,     first_done_next;
    logic [31:0] first_stamp_reg,    first_stamp_next;
    logic [31:0] last_stamp_reg,     last_stamp_next;
    logic        stamp_seen_reg,     stamp_seen_next;
    logic [30:0] max_gap_reg,        max_gap_next;
    logic [15:0] fields_first_reg,   fields_first_next;
    logic [15:0] fields_other_reg,   fields_other_next;
    logic        fields_differ_reg,  fields_differ_next;
    logic [31:0] sub_over_reg,       sub_over_next;
    logic [31:0] backward_reg,       backward_next;
    logic [31:0] arrival_time_reg,   arrival_time_next;
    logic        arrival_seen_reg,   arrival_seen_next;
    logic [31:0] offset_first_reg,   offset_first_next;
    logic [31:0] offset_last_reg,    offset_last_next;
    logic [31:0] skew_start_reg,     skew_start_next;
    logic [31:0] skew_end_reg,       skew_end_next;
    logic        skew_seen_reg,      skew_seen_next;

    logic        advance;
    logic [31:0] stamp_diff;
    logic [31:0] offset_now;

    assign advance   = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;

    assign stamp_diff = stamp_reg - last_stamp_reg;
    assign offset_now = arrival_time_reg - stamp_reg;

    always_comb
    begin
        sample_total_next   = sample_total_reg;
        batch_total_next    = batch_total_reg;
        connect_time_next   = connect_time_reg;
        connected_seen_next = connected_seen_reg;
        first_latency_next  = first_latency_reg;
        first_done_next     = first_done_reg;
        first_stamp_next    = first_stamp_reg;
        last_stamp_next     = last_stamp_reg;
        stamp_seen_next     = stamp_seen_reg;
        max_gap_next        = max_gap_reg;
        fields_first_next   = fields_first_reg;
        fields_other_next   = fields_other_reg;
        fields_differ_next  = fields_differ_reg;
        sub_over_next       = sub_over_reg;
        backward_next       = backward_reg;
        arrival_time_next   = arrival_time_reg;
        arrival_seen_next   = arrival_seen_reg;
        offset_first_next   = offset_first_reg;
        offset_last_next    = offset_last_reg;
        skew_start_next     = skew_start_reg;
        skew_end_next       = skew_end_reg;
        skew_seen_next      = skew_seen_reg;

        unique case (func_reg)
            FUNC_CONNECT:
            begin
                connect_time_next   = uptime_reg;
                connected_seen_next = 1'b1;
            end
            FUNC_BATCH:
            begin
                batch_total_next  = sat_inc(batch_total_reg);
                arrival_time_next = uptime_reg;
                arrival_seen_next = 1'b1;
                if (fc_reg != 16'd0)
                begin
                    if (fields_first_reg == 16'd0)
                    begin
                        fields_first_next = fc_reg;
                    end
                    else if (fc_reg != fields_first_reg)
                    begin
                        fields_differ_next = 1'b1;
                        fields_other_next  = fc_reg;
                    end
                end
            end
            FUNC_SAMPLE:
            begin
                if (sub_reg > SUB_US_MAX)
                begin
                    sub_over_next = sat_inc(sub_over_reg);
                end
                if (!first_done_reg && connected_seen_reg)
                begin
                    first_done_next    = 1'b1;
                    first_latency_next = arrival_seen_reg
                                       ? fwd_elapsed(connect_time_reg, arrival_time_reg)
                                       : 31'd0;
                end
                if (stamp_seen_reg)
                begin
                    if (stamp_diff[31])
                    begin
                        backward_next = sat_inc(backward_reg);
                    end
                    else if (stamp_diff[30:0] > max_gap_reg)
                    begin
                        max_gap_next = stamp_diff[30:0];
                    end
                end
                else
                begin
                    first_stamp_next = stamp_reg;
                    stamp_seen_next  = 1'b1;
                end
                last_stamp_next   = stamp_reg;
                sample_total_next = sat_inc(sample_total_reg);
                if (arrival_seen_reg)
                begin
                    if (!skew_seen_reg)
                    begin
                        offset_first_next = offset_now;
                        skew_start_next   = arrival_time_reg;
                    end
                    offset_last_next = offset_now;
                    skew_end_next    = arrival_time_reg;
                    skew_seen_next   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            func_reg   <= func_t'(func);
            uptime_reg <= uptime_ms;
            fc_reg     <= field_count;
            stamp_reg  <= stamp_ms;
            sub_reg    <= stamp_sub_us;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_total_reg   <= '0;
            batch_total_reg    <= '0;
            connect_time_reg   <= '0;
            connected_seen_reg <= 1'b0;
            first_latency_reg  <= '0;
            first_done_reg     <= 1'b0;
            first_stamp_reg    <= '0;
            last_stamp_reg     <= '0;
            stamp_seen_reg     <= 1'b0;
            max_gap_reg        <= '0;
            fields_first_reg   <= '0;
            fields_other_reg   <= '0;
            fields_differ_reg  <= 1'b0;
            sub_over_reg       <= '0;
            backward_reg       <= '0;
            arrival_time_reg   <= '0;
            arrival_seen_reg   <= 1'b0;
            offset_first_reg   <= '0;
            offset_last_reg    <= '0;
            skew_start_reg     <= '0;
            skew_end_reg       <= '0;
            skew_seen_reg      <= 1'b0;
        end
        else if (advance)
        begin
            sample_total_reg   <= sample_total_next;
            batch_total_reg    <= batch_total_next;
            connect_time_reg   <= connect_time_next;
            connected_seen_reg <= connected_seen_next;
            first_latency_reg  <= first_latency_next;
            first_done_reg     <= first_done_next;
            first_stamp_reg    <= first_stamp_next;
            last_stamp_reg     <= last_stamp_next;
            stamp_seen_reg     <= stamp_seen_next;
            max_gap_reg        <= max_gap_next;
            fields_first_reg   <= fields_first_next;
            fields_other_reg   <= fields_other_next;
            fields_differ_reg  <= fields_differ_next;
            sub_over_reg       <= sub_over_next;
            backward_reg       <= backward_next;
            arrival_time_reg   <= arrival_time_next;
            arrival_seen_reg   <= arrival_seen_next;
            offset_first_reg   <= offset_first_next;
            offset_last_reg    <= offset_last_next;
            skew_start_reg     <= skew_start_next;
            skew_end_reg       <= skew_end_next;
            skew_seen_reg      <= skew_seen_next;
        end
    end

    // result snapshot, taken from the updated statistics
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            total_samples           <= sample_total_next;
            total_batches           <= batch_total_next;
            longest_gap_ms          <= max_gap_next;
            backward_count          <= backward_next;
            bad_sub_count           <= sub_over_next;
            first_fields            <= fields_first_next;
            other_fields            <= fields_other_next;
            fields_changed          <= fields_differ_next;
            first_sample_latency_ms <= first_latency_next;
            offset_drift_ms         <= signed'(offset_last_next - offset_first_next);
            skew_span_ms            <= fwd_elapsed(skew_start_next, skew_end_next);
            stamp_span_ms           <= fwd_elapsed(first_stamp_next, last_stamp_next);
        end
    end

endmodule

>>> verif/tb_sensor_stream_timing_monitor_core.sv
`timescale 1ns / 1ps

module tb_sensor_stream_timing_monitor_core
    import sstm_pkg::*;
;

    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_LIMIT  = 1000;
    localparam int RANDOM_REQS = 400;

    typedef struct packed {
        func_t       kind;
        logic [31:0] uptime;
        logic [15:0] fields;
        logic [31:0] stamp;
        logic [15:0] sub_us;
    } event_t;

    typedef struct packed {
        logic [31:0] total_samples;
        logic [31:0] total_batches;
        logic [30:0] longest_gap_ms;
        logic [31:0] backward_count;
        logic [31:0] bad_sub_count;
        logic [15:0] first_fields;
        logic [15:0] other_fields;
        logic        fields_changed;
        logic [30:0] first_sample_latency_ms;
        logic [31:0] offset_drift_ms;
        logic [30:0] skew_span_ms;
        logic [30:0] stamp_span_ms;
    } snapshot_t;

    typedef struct packed {
        event_t    ev;
        logic      typed;
        snapshot_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [31:0] uptime_ms;
    logic [15:0] field_count;
    logic [31:0] stamp_ms;
    logic [15:0] stamp_sub_us;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] total_samples;
    logic [31:0] total_batches;
    logic [30:0] longest_gap_ms;
    logic [31:0] backward_count;
    logic [31:0] bad_sub_count;
    logic [15:0] first_fields;
    logic [15:0] other_fields;
    logic        fields_changed;
    logic [30:0] first_sample_latency_ms;
    logic signed [31:0] offset_drift_ms;
    logic [30:0] skew_span_ms;
    logic [30:0] stamp_span_ms;

    sensor_stream_timing_monitor_core uut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_stall                (in_stall),
        .func                    (func),
        .uptime_ms               (uptime_ms),
        .field_count             (field_count),
        .stamp_ms                (stamp_ms),
        .stamp_sub_us            (stamp_sub_us),
        .out_valid               (out_valid),
        .out_stall               (out_stall),
        .total_samples           (total_samples),
        .total_batches           (total_batches),
        .longest_gap_ms          (longest_gap_ms),
        .backward_count          (backward_count),
        .bad_sub_count           (bad_sub_count),
        .first_fields            (first_fields),
        .other_fields            (other_fields),
        .fields_changed          (fields_changed),
        .first_sample_latency_ms (first_sample_latency_ms),
        .offset_drift_ms         (offset_drift_ms),
        .skew_span_ms            (skew_span_ms),
        .stamp_span_ms           (stamp_span_ms)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // timing statistics as the block should hold them
    logic [31:0] n_samples, n_batches, n_bad_sub, n_backward, n_points;
    logic [31:0] conn_ms, arr_ms, lat_ms, gap_max;
    logic [31:0] stamp_first, stamp_last;
    logic [31:0] off_first, off_last, skew_from, skew_to;
    logic [15:0] fc_first, fc_other;
    logic        conn_seen, arr_seen, lat_fixed, have_stamp, fc_differ;

    snapshot_t stats_due[$];
    dir_row_t  dir_tab[$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    int        random_sent = 0;
    bit        tx_fast = 1'b0;
    bit        rx_fast = 1'b0;
    bit        rx_hold = 1'b0;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // forward distance between two wrapping ms times, 0 if not strictly ahead
    function automatic logic [30:0] forward_ms(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = b - a;
        return (d < 32'h8000_0000) ? d[30:0] : 31'd0;
    endfunction

    function automatic event_t mk_event(input func_t k, input logic [31:0] up,
                                        input logic [15:0] fc, input logic [31:0] st,
                                        input logic [15:0] sub);
        event_t e;
        e.kind   = k;
        e.uptime = up;
        e.fields = fc;
        e.stamp  = st;
        e.sub_us = sub;
        return e;
    endfunction

    task automatic advance_stats(input event_t e, output snapshot_t s);
        logic [31:0] d;
        logic [31:0] off;
        case (e.kind)
            FUNC_CONNECT:
            begin
                conn_ms   = e.uptime;
                conn_seen = 1'b1;
            end
            FUNC_BATCH:
            begin
                n_batches = bump(n_batches);
                arr_ms    = e.uptime;
                arr_seen  = 1'b1;
                if (e.fields != 16'd0)
                begin
                    if (fc_first == 16'd0)
                        fc_first = e.fields;
                    else if (e.fields != fc_first)
                    begin
                        fc_differ = 1'b1;
                        fc_other  = e.fields;
                    end
                end
            end
            FUNC_SAMPLE:
            begin
                if (e.sub_us > SUB_US_MAX)
                    n_bad_sub = bump(n_bad_sub);
                if (!lat_fixed && conn_seen)
                begin
                    lat_fixed = 1'b1;
                    lat_ms    = arr_seen ? {1'b0, forward_ms(conn_ms, arr_ms)} : 32'd0;
                end
                if (have_stamp)
                begin
                    d = e.stamp - stamp_last;
                    if (d[31])
                        n_backward = bump(n_backward);
                    else if (d > gap_max)
                        gap_max = d;
                end
                else
                begin
                    stamp_first = e.stamp;
                    have_stamp  = 1'b1;
                end
                stamp_last = e.stamp;
                n_samples  = bump(n_samples);
                if (arr_seen)
                begin
                    off = arr_ms - e.stamp;
                    if (n_points == 32'd0)
                    begin
                        off_first = off;
                        skew_from = arr_ms;
                    end
                    off_last = off;
                    skew_to  = arr_ms;
                    n_points = bump(n_points);
                end
            end
            default: ;
        endcase
        s.total_samples           = n_samples;
        s.total_batches           = n_batches;
        s.longest_gap_ms          = gap_max[30:0];
        s.backward_count          = n_backward;
        s.bad_sub_count           = n_bad_sub;
        s.first_fields            = fc_first;
        s.other_fields            = fc_other;
        s.fields_changed          = fc_differ;
        s.first_sample_latency_ms = lat_ms[30:0];
        s.offset_drift_ms         = off_last - off_first;
        s.skew_span_ms            = forward_ms(skew_from, skew_to);
        s.stamp_span_ms           = have_stamp ? forward_ms(stamp_first, stamp_last) : 31'd0;
    endtask

    task automatic add_row(input event_t e, input logic typed, input snapshot_t want);
        dir_row_t r;
        r.ev    = e;
        r.typed = typed;
        r.want  = want;
        dir_tab.push_back(r);
    endtask

    // drives one request from the falling edge and returns at the falling edge after acceptance
    task automatic offer(input event_t e, input logic typed, input snapshot_t want);
        int        gap;
        snapshot_t s;
        gap = tx_fast ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid     <= 1'b0;
            func         <= 2'($urandom_range(0, 3));
            uptime_ms    <= $urandom;
            field_count  <= 16'($urandom_range(0, 65535));
            stamp_ms     <= $urandom;
            stamp_sub_us <= 16'($urandom_range(0, 65535));
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= e.kind;
        uptime_ms    <= e.uptime;
        field_count  <= e.fields;
        stamp_ms     <= e.stamp;
        stamp_sub_us <= e.sub_us;
        do @(posedge clk); while (in_stall);
        advance_stats(e, s);
        stats_due.push_back(typed ? want : s);
        @(negedge clk);
    endtask

    task automatic offer_noise();
        offer(mk_event(func_t'(2'($urandom_range(0, 3))), $urandom,
                       16'($urandom_range(0, 65535)), $urandom,
                       16'($urandom_range(0, 65535))), 1'b0, '0);
        random_sent++;
    endtask

    // an optional connect, then rounds of a batch arrival followed by its samples
    task automatic offer_session();
        int          rounds;
        int          n;
        logic [31:0] up;
        logic [31:0] st;
        logic [15:0] fc;
        logic [15:0] fc_now;
        logic [15:0] sub;
        tx_fast = ($urandom_range(0, 5) == 0);
        rx_fast = ($urandom_range(0, 5) == 0);
        up = $urandom;
        st = $urandom;
        fc = 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 3) != 0)
        begin
            offer(mk_event(FUNC_CONNECT, up, 16'($urandom_range(0, 65535)), $urandom,
                           16'($urandom_range(0, 65535))), 1'b0, '0);
            random_sent++;
        end
        rounds = $urandom_range(1, 4);
        repeat (rounds)
        begin
            up = up + $urandom_range(0, 3000);
            case ($urandom_range(0, 9))
                0:       fc_now = 16'd0;
                1:       fc_now = 16'($urandom_range(1, 65535));
                default: fc_now = fc;
            endcase
            offer(mk_event(FUNC_BATCH, up, fc_now, $urandom,
                           16'($urandom_range(0, 65535))), 1'b0, '0);
            random_sent++;
            n = $urandom_range(1, 6);
            repeat (n)
            begin
                case ($urandom_range(0, 19))
                    0, 1:    st = st - $urandom_range(1, 1000);
                    2:       st = $urandom;
                    default: st = st + $urandom_range(0, 500);
                endcase
                sub = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1000, 65535))
                                                  : 16'($urandom_range(0, 999));
                offer(mk_event(FUNC_SAMPLE, $urandom, 16'($urandom_range(0, 65535)), st,
                               sub), 1'b0, '0);
                random_sent++;
            end
        end
    endtask

    // sender holds off until every expected result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (stats_due.size() != 0);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic build_table();
        snapshot_t w;
        // after reset, unused selector with every input bit set
        add_row(mk_event(FUNC_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF),
                1'b1, '0);
        // sample before any connect or batch: latency stays unset
        w = '0;
        w.total_samples = 32'd1;
        w.bad_sub_count = 32'd1;
        add_row(mk_event(FUNC_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF),
                1'b1, w);
        w.total_batches = 32'd1;
        add_row(mk_event(FUNC_BATCH, 32'd0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, w);
        add_row(mk_event(FUNC_CONNECT, 32'hFFFF_FFF0, 16'h1234, 32'h5555, 16'h03E8),
                1'b1, w);
        w.total_batches = 32'd2;
        w.first_fields  = 16'hFFFF;
        add_row(mk_event(FUNC_BATCH, 32'h0000_0010, 16'hFFFF, 32'd0, 16'd0), 1'b1, w);
        // latency across the uptime wrap, gap across the stamp wrap
        w.total_samples           = 32'd2;
        w.longest_gap_ms          = 31'd1;
        w.first_sample_latency_ms = 31'h20;
        w.stamp_span_ms           = 31'd1;
        add_row(mk_event(FUNC_SAMPLE, 32'd0, 16'd0, 32'd0, 16'd999), 1'b1, w);
        add_row(mk_event(FUNC_SAMPLE, 32'h1234_5678, 16'h00FF, 32'h7FFF_FFFF, 16'd1000),
                1'b0, '0);
        add_row(mk_event(FUNC_SAMPLE, 32'd0, 16'd0, 32'd0, 16'd0), 1'b0, '0);
        add_row(mk_event(FUNC_BATCH, 32'h8000_0010, 16'd1, 32'hFFFF_FFFF, 16'hFFFF),
                1'b0, '0);
        add_row(mk_event(FUNC_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF, 32'd5, 16'd500), 1'b0, '0);
        add_row(mk_event(FUNC_BATCH, 32'h8000_0000, 16'hFFFF, 32'd0, 16'd0), 1'b0, '0);
        add_row(mk_event(FUNC_BATCH, 32'd0, 16'd0, 32'd0, 16'd0), 1'b0, '0);
        // reconnect must not move the latency
        add_row(mk_event(FUNC_CONNECT, 32'd0, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF), 1'b0, '0);
        add_row(mk_event(FUNC_SAMPLE, 32'd0, 16'd0, 32'd5, 16'd999), 1'b0, '0);
        // exactly half the range ahead reads as backwards
        add_row(mk_event(FUNC_SAMPLE, 32'd0, 16'd0, 32'h8000_0005, 16'd0), 1'b0, '0);
        add_row(mk_event(FUNC_NONE, 32'hAAAA_AAAA, 16'h5555, 32'h5555_5555, 16'hAAAA),
                1'b0, '0);
        add_row(mk_event(FUNC_BATCH, 32'hFFFF_FFFF, 16'd2, 32'd0, 16'd0), 1'b0, '0);
        add_row(mk_event(FUNC_SAMPLE, 32'd0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF), 1'b0, '0);
        add_row(mk_event(FUNC_SAMPLE, 32'd0, 16'd0, 32'h7FFF_FFFE, 16'd0), 1'b0, '0);
    endtask

    // request side
    initial
    begin
        bit hold_done;
        bit pause_done;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_stall    = 1'b0;
        func         = 2'd0;
        uptime_ms    = 32'd0;
        field_count  = 16'd0;
        stamp_ms     = 32'd0;
        stamp_sub_us = 16'd0;
        n_samples = '0; n_batches = '0; n_bad_sub = '0; n_backward = '0; n_points = '0;
        conn_ms = '0; arr_ms = '0; lat_ms = '0; gap_max = '0;
        stamp_first = '0; stamp_last = '0;
        off_first = '0; off_last = '0; skew_from = '0; skew_to = '0;
        fc_first = '0; fc_other = '0;
        conn_seen = 1'b0; arr_seen = 1'b0; lat_fixed = 1'b0;
        have_stamp = 1'b0; fc_differ = 1'b0;
        build_table();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            offer(dir_tab[i].ev, dir_tab[i].typed, dir_tab[i].want);
        drain();

        while (random_sent < RANDOM_REQS)
        begin
            if (!hold_done && random_sent > 120)
            begin
                // result side stops while requests keep coming back to back
                hold_done = 1'b1;
                rx_hold   = 1'b1;
                tx_fast   = 1'b1;
                repeat (24) offer_noise();
                tx_fast   = 1'b0;
            end
            else if (!pause_done && random_sent > 260)
            begin
                pause_done = 1'b1;
                drain();
            end
            else if ($urandom_range(0, 4) != 0)
                offer_session();
            else
                offer_noise();
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && stats_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // result side
    initial
    begin
        int        wait_n;
        snapshot_t got;
        snapshot_t want;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (rx_hold)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold = 1'b0;
            end
            else
            begin
                wait_n = rx_fast ? 0 : $urandom_range(0, 17);
                if (wait_n != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (wait_n) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got.total_samples           = total_samples;
            got.total_batches           = total_batches;
            got.longest_gap_ms          = longest_gap_ms;
            got.backward_count          = backward_count;
            got.bad_sub_count           = bad_sub_count;
            got.first_fields            = first_fields;
            got.other_fields            = other_fields;
            got.fields_changed          = fields_changed;
            got.first_sample_latency_ms = first_sample_latency_ms;
            got.offset_drift_ms         = offset_drift_ms;
            got.skew_span_ms            = skew_span_ms;
            got.stamp_span_ms           = stamp_span_ms;
            if (stats_due.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = stats_due.pop_front();
                check_field("total_samples", want.total_samples, got.total_samples);
                check_field("total_batches", want.total_batches, got.total_batches);
                check_field("longest_gap_ms", 32'(want.longest_gap_ms),
                            32'(got.longest_gap_ms));
                check_field("backward_count", want.backward_count, got.backward_count);
                check_field("bad_sub_count", want.bad_sub_count, got.bad_sub_count);
                check_field("first_fields", 32'(want.first_fields), 32'(got.first_fields));
                check_field("other_fields", 32'(want.other_fields), 32'(got.other_fields));
                check_field("fields_changed", 32'(want.fields_changed),
                            32'(got.fields_changed));
                check_field("first_sample_latency_ms", 32'(want.first_sample_latency_ms),
                            32'(got.first_sample_latency_ms));
                check_field("offset_drift_ms", want.offset_drift_ms, got.offset_drift_ms);
                check_field("skew_span_ms", 32'(want.skew_span_ms), 32'(got.skew_span_ms));
                check_field("stamp_span_ms", 32'(want.stamp_span_ms),
                            32'(got.stamp_span_ms));
            end
            @(negedge clk);
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

>>> sensor_stream_timing_monitor_core.f
hdl/sstm_pkg.sv
hdl/sensor_stream_timing_monitor_core.sv
verif/tb_sensor_stream_timing_monitor_core.sv
